FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and helpers shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DAYS   = 7;
    localparam int DAY_W  = 3;
    localparam int PRIO_W = 7;
    localparam int MOD_W  = 11;
    localparam int TAG_W  = 16;
    localparam int OCC_W  = 7;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic [PRIO_W-1:0] PRIO_MIN = 7'd1;
    localparam logic [PRIO_W-1:0] PRIO_MAX = 7'd100;
    localparam logic [5:0]        HOURS    = 6'd24;
    localparam logic [5:0]        MINUTES  = 6'd60;
    localparam logic [MOD_W-1:0]  MIN_PER_HOUR = 11'd60;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [PRIO_W-1:0] priority_req;
        logic [5:0]        hour;
        logic [5:0]        minute;
        logic [7:0]        day_letter;
        logic [TAG_W-1:0]  tag;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [PRIO_W-1:0] out_priority;
        logic [MOD_W-1:0]  out_minute_of_day;
        logic [DAY_W-1:0]  out_day_index;
        logic [TAG_W-1:0]  out_tag;
        logic [OCC_W-1:0]  occupancy;
    } res_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [MOD_W-1:0]  mod;
        logic [DAY_W-1:0]  day;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   pop;
        entry_t new_entry;
    } cell_ctrl_t;

    typedef struct packed {
        logic             inc;
        logic [DAY_W-1:0] inc_day;
        logic             dec;
        logic [DAY_W-1:0] dec_day;
    } tally_ctrl_t;

    typedef struct packed {
        logic             ok;
        logic [DAY_W-1:0] idx;
    } day_code_t;

    function automatic day_code_t decode_day(input logic [7:0] letter);
        day_code_t r;
        r.ok = 1'b1;
        case (letter)
            8'h4C:   r.idx = 3'd0;  // L
            8'h4D:   r.idx = 3'd1;  // M
            8'h58:   r.idx = 3'd2;  // X
            8'h4A:   r.idx = 3'd3;  // J
            8'h56:   r.idx = 3'd4;  // V
            8'h53:   r.idx = 3'd5;  // S
            8'h44:   r.idx = 3'd6;  // D
            default:
            begin
                r.ok  = 1'b0;
                r.idx = 3'd0;
            end
        endcase
        return r;
    endfunction

    // true when key (p, m) sorts ahead of or equal to entry e
    function automatic logic goes_before(input logic [PRIO_W-1:0] p,
                                         input logic [MOD_W-1:0] m,
                                         input entry_t e);
        return (p < e.prio) || ((p == e.prio) && (m <= e.mod));
    endfunction

endpackage

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_valid,
    input  logic               left_goes,
    input  spq_pkg::entry_t    right_entry,
    input  logic               right_valid,
    output spq_pkg::entry_t    entry,
    output logic               valid,
    output logic               goes
);
    import spq_pkg::*;

    entry_t entry_reg, entry_next;
    logic   valid_reg, valid_next;

    // empty slots always take part in the shift
    assign goes  = !valid_reg ||
                   goes_before(ctrl.new_entry.prio, ctrl.new_entry.mod, entry_reg);
    assign entry = entry_reg;
    assign valid = valid_reg;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.ins && goes)
        begin
            if (left_goes)
            begin
                entry_next = left_entry;
                valid_next = left_valid;
            end
            else
            begin
                entry_next = ctrl.new_entry;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: rtl/spq_tally.sv
// ----------------------------------------------------------------------------
// spq_tally
// Per-weekday entry counters and the busiest-weekday pick.
// ----------------------------------------------------------------------------
module spq_tally #(
    parameter int CNT_W = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  spq_pkg::tally_ctrl_t  ctrl,
    output logic [spq_pkg::DAY_W-1:0] busiest
);
    import spq_pkg::*;

    logic [CNT_W-1:0] count_reg  [DAYS];
    logic [CNT_W-1:0] count_next [DAYS];

    always_comb
    begin
        for (int i = 0; i < DAYS; i++)
        begin
            count_next[i] = count_reg[i];
            if (ctrl.inc && (ctrl.inc_day == DAY_W'(i)))
            begin
                count_next[i] = count_reg[i] + CNT_W'(1);
            end
            if (ctrl.dec && (ctrl.dec_day == DAY_W'(i)) && (count_reg[i] != '0))
            begin
                count_next[i] = count_reg[i] - CNT_W'(1);
            end
        end
    end

    // strict compare keeps the earliest weekday on a tie
    always_comb
    begin
        logic [CNT_W-1:0] best_cnt;
        best_cnt = count_reg[0];
        busiest  = '0;
        for (int i = 1; i < DAYS; i++)
        begin
            if (count_reg[i] > best_cnt)
            begin
                best_cnt = count_reg[i];
                busiest  = DAY_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DAYS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < DAYS; i++)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule

FILE: rtl/sorted_priority_queue_with_day_tally.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_day_tally
// Insertion-sorted priority queue built as a row of shifting cells,
// with a per-weekday count of queued entries.
// ----------------------------------------------------------------------------
// the result of an item is registered when it is accepted and shown in the next cycle
// throughput: one item per cycle, cmd_ready low while a result is unread; each
//   cell compares its key with the broadcast item and shifts in the same cycle
// reset: all cells empty, entry count and weekday counts zero, result empty;
//   no clearing pass, the queue is usable in the first cycle after reset
module sorted_priority_queue_with_day_tally #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  spq_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output spq_pkg::res_t res
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             res_valid_reg;
    res_t             res_reg, res_next;

    cell_ctrl_t  cctrl;
    tally_ctrl_t tctrl;
    logic [DAY_W-1:0] busiest;

    entry_t cell_entry [QUEUE_DEPTH];
    logic   cell_valid [QUEUE_DEPTH];
    logic   cell_goes  [QUEUE_DEPTH];

    logic      accept;
    day_code_t dc;
    logic      fields_ok;
    logic      full;
    logic      empty;

    assign cmd_ready = !res_valid_reg || res_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign dc        = decode_day(cmd.day_letter);
    assign fields_ok = (cmd.hour < HOURS) && (cmd.minute < MINUTES) && dc.ok &&
                       (cmd.priority_req >= PRIO_MIN) && (cmd.priority_req <= PRIO_MAX);
    assign full      = (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        cctrl.new_entry.prio = cmd.priority_req;
        cctrl.new_entry.mod  = (MOD_W'(cmd.hour) * MIN_PER_HOUR) + MOD_W'(cmd.minute);
        cctrl.new_entry.day  = dc.idx;
        cctrl.new_entry.tag  = cmd.tag;
        cctrl.ins = 1'b0;
        cctrl.pop = 1'b0;

        tctrl.inc     = 1'b0;
        tctrl.inc_day = dc.idx;
        tctrl.dec     = 1'b0;
        tctrl.dec_day = cell_entry[0].day;

        count_next = count_reg;
        res_next   = '0;
        res_next.status = ST_OK;

        case (cmd.opcode)
            OP_INSERT:
            begin
                if (!fields_ok)
                begin
                    res_next.status = ST_INVALID;
                end
                else if (full)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    cctrl.ins  = accept;
                    tctrl.inc  = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    cctrl.pop  = accept;
                    tctrl.dec  = accept;
                    count_next = count_reg - CNT_W'(1);
                    res_next.out_priority      = cell_entry[0].prio;
                    res_next.out_minute_of_day = cell_entry[0].mod;
                    res_next.out_day_index     = cell_entry[0].day;
                    res_next.out_tag           = cell_entry[0].tag;
                end
            end
            OP_QUERY:
            begin
                if (empty)
                begin
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    res_next.out_day_index = busiest;
                end
            end
            default:
            begin
                res_next.status = ST_INVALID;
            end
        endcase

        res_next.occupancy = OCC_W'(count_next);
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            entry_t l_entry, r_entry;
            logic   l_valid, l_goes, r_valid;

            if (g == 0)
            begin : g_head
                assign l_entry = '0;
                assign l_valid = 1'b0;
                assign l_goes  = 1'b0;
            end
            else
            begin : g_mid
                assign l_entry = cell_entry[g-1];
                assign l_valid = cell_valid[g-1];
                assign l_goes  = cell_goes[g-1];
            end

            if (g == QUEUE_DEPTH - 1)
            begin : g_tail
                assign r_entry = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_body
                assign r_entry = cell_entry[g+1];
                assign r_valid = cell_valid[g+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cctrl),
                .left_entry  (l_entry),
                .left_valid  (l_valid),
                .left_goes   (l_goes),
                .right_entry (r_entry),
                .right_valid (r_valid),
                .entry       (cell_entry[g]),
                .valid       (cell_valid[g]),
                .goes        (cell_goes[g])
            );
        end
    endgenerate

    spq_tally #(
        .CNT_W (CNT_W)
    ) u_tally (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (tctrl),
        .busiest (busiest)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: test/spq_result_checker.sv
// ----------------------------------------------------------------------------
// spq_result_checker
// Watches the command and result channels of the sorted priority queue.
// Keeps its own sorted entry list and weekday counts, works out the
// expected result of every accepted command, and compares each accepted
// result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module spq_result_checker #(
    parameter int DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  logic          cmd_ready,
    input  spq_pkg::cmd_t cmd,
    input  logic          res_valid,
    input  logic          res_ready,
    input  spq_pkg::res_t res,
    output int unsigned   error_count,
    output int unsigned   results_due_count
);
    import spq_pkg::*;

    localparam logic [7:0] WEEKDAY_LETTER [DAYS] = '{"L", "M", "X", "J", "V", "S", "D"};
    localparam int unsigned REPORT_LIMIT = 10;

    entry_t      sorted_entries [$];
    int unsigned weekday_tally [DAYS];
    res_t        results_due [$];
    int unsigned errors;

    // applies one command to the mirrored queue and returns its result
    function automatic res_t predict_result(input cmd_t c);
        res_t        r;
        entry_t      e;
        int unsigned day;
        int unsigned pos;
        int unsigned best;
        r = '0;
        r.status = ST_OK;
        case (c.opcode)
            OP_INSERT:
            begin
                day = DAYS;
                for (int i = 0; i < DAYS; i++)
                begin
                    if (c.day_letter == WEEKDAY_LETTER[i])
                        day = i;
                end
                if (c.hour >= HOURS || c.minute >= MINUTES || day == DAYS
                    || c.priority_req < PRIO_MIN || c.priority_req > PRIO_MAX)
                    r.status = ST_INVALID;
                else if (sorted_entries.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    e.prio = c.priority_req;
                    e.mod  = c.hour * MIN_PER_HOUR + c.minute;
                    e.day  = day[DAY_W-1:0];
                    e.tag  = c.tag;
                    // new entry lands ahead of the first one with an equal or larger key
                    pos = 0;
                    while (pos < sorted_entries.size()
                           && !(e.prio < sorted_entries[pos].prio
                                || (e.prio == sorted_entries[pos].prio
                                    && e.mod <= sorted_entries[pos].mod)))
                        pos++;
                    sorted_entries.insert(pos, e);
                    weekday_tally[day]++;
                end
            end
            OP_POP:
            begin
                if (sorted_entries.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    e = sorted_entries.pop_front();
                    if (weekday_tally[e.day] > 0)
                        weekday_tally[e.day]--;
                    r.out_priority      = e.prio;
                    r.out_minute_of_day = e.mod;
                    r.out_day_index     = e.day;
                    r.out_tag           = e.tag;
                end
            end
            OP_QUERY:
            begin
                if (sorted_entries.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    // strict compare keeps the earliest weekday on a tie
                    best = 0;
                    for (int i = 1; i < DAYS; i++)
                    begin
                        if (weekday_tally[i] > weekday_tally[best])
                            best = i;
                    end
                    r.out_day_index = best[DAY_W-1:0];
                end
            end
            default:
            begin
                r.status = ST_INVALID;
            end
        endcase
        r.occupancy = OCC_W'(sorted_entries.size());
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            sorted_entries.delete();
            results_due.delete();
            weekday_tally     = '{default: 0};
            errors            = 0;
            error_count       <= 0;
            results_due_count <= 0;
        end
        else
        begin
            // a result at this edge belongs to an earlier command
            if (res_valid && res_ready)
            begin
                if (results_due.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: result item with nothing expected: %h", $realtime, res);
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("status", 16'(want.status), 16'(res.status));
                    check_field("out_priority", 16'(want.out_priority), 16'(res.out_priority));
                    check_field("out_minute_of_day", 16'(want.out_minute_of_day),
                                16'(res.out_minute_of_day));
                    check_field("out_day_index", 16'(want.out_day_index),
                                16'(res.out_day_index));
                    check_field("out_tag", want.out_tag, res.out_tag);
                    check_field("occupancy", 16'(want.occupancy), 16'(res.occupancy));
                end
            end
            if (cmd_valid && cmd_ready)
                results_due.push_back(predict_result(cmd));
            error_count       <= errors;
            results_due_count <= results_due.size();
        end
    end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the sorted priority queue with a directed opening (bad fields,
// empty queue, ties on key, weekday ties) and then random fill and drain
// runs under four idling mixes. The checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam logic [7:0] WEEKDAY_LETTER [DAYS] = '{"L", "M", "X", "J", "V", "S", "D"};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    cmd_t        cmd       = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_t        res;
    int unsigned error_count;
    int unsigned results_due_count;
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    sorted_priority_queue_with_day_tally #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    spq_result_checker #(
        .DEPTH(QUEUE_DEPTH)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (cmd_valid),
        .cmd_ready         (cmd_ready),
        .cmd               (cmd),
        .res_valid         (res_valid),
        .res_ready         (res_ready),
        .res               (res),
        .error_count       (error_count),
        .results_due_count (results_due_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (stall_pct == 0)
            res_ready <= 1'b1;
        else
            res_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #5_000_000;
        $display("[sorted_priority_queue_with_day_tally] ERROR");
        $finish;
    end

    function automatic cmd_t make_cmd(input logic [1:0] op, input int unsigned prio,
                                      input int unsigned hr, input int unsigned mn,
                                      input logic [7:0] letter, input logic [15:0] tag);
        cmd_t c;
        c.opcode       = op;
        c.priority_req = prio[PRIO_W-1:0];
        c.hour         = hr[5:0];
        c.minute       = mn[5:0];
        c.day_letter   = letter;
        c.tag          = tag;
        return c;
    endfunction

    function automatic logic [7:0] any_letter();
        if ($urandom_range(1) == 0)
            return WEEKDAY_LETTER[$urandom_range(DAYS - 1)];
        return 8'($urandom);
    endfunction

    // well-formed insert; a narrow key range half the time so keys collide
    function automatic cmd_t random_insert();
        if ($urandom_range(1) == 0)
            return make_cmd(OP_INSERT, $urandom_range(3, 1), 0, $urandom_range(2),
                            WEEKDAY_LETTER[$urandom_range(DAYS - 1)], 16'($urandom));
        return make_cmd(OP_INSERT, $urandom_range(100, 1), $urandom_range(23),
                        $urandom_range(59), WEEKDAY_LETTER[$urandom_range(DAYS - 1)],
                        16'($urandom));
    endfunction

    function automatic cmd_t random_noise();
        return make_cmd(2'($urandom_range(3)), $urandom_range(127), $urandom_range(63),
                        $urandom_range(63), any_letter(), 16'($urandom));
    endfunction

    function automatic cmd_t random_drain();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return make_cmd(OP_POP, $urandom_range(127), $urandom_range(63),
                            $urandom_range(63), any_letter(), 16'($urandom));
        if (pick < 85)
            return make_cmd(OP_QUERY, $urandom_range(127), $urandom_range(63),
                            $urandom_range(63), any_letter(), 16'($urandom));
        return random_insert();
    endfunction

    // called and returns at a rising edge
    task automatic send_item(input cmd_t c);
        logic ready_seen;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
        begin
            @(negedge clk);
            ready_seen = cmd_ready;
            @(posedge clk);
        end
        while (!ready_seen);
    endtask

    task automatic hold_until_drained();
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_due_count != 0);
        @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue and the unused opcode
        send_item(make_cmd(OP_POP, 5, 1, 1, "L", 16'h1234));
        send_item(make_cmd(OP_QUERY, 5, 1, 1, "L", 16'h1234));
        send_item(make_cmd(2'd3, 7, 2, 3, "M", 16'hbeef));
        // each field just outside its valid set
        send_item(make_cmd(OP_INSERT, 0, 0, 0, "L", 16'h0001));
        send_item(make_cmd(OP_INSERT, 101, 0, 0, "L", 16'h0002));
        send_item(make_cmd(OP_INSERT, 127, 0, 0, "L", 16'h0003));
        send_item(make_cmd(OP_INSERT, 10, 24, 0, "L", 16'h0004));
        send_item(make_cmd(OP_INSERT, 10, 0, 60, "L", 16'h0005));
        send_item(make_cmd(OP_INSERT, 10, 0, 0, 8'h00, 16'h0006));
        send_item(make_cmd(OP_INSERT, 10, 0, 0, 8'hff, 16'h0007));
        // field extremes, equal keys, one entry per weekday
        send_item(make_cmd(OP_INSERT, 100, 23, 59, "D", 16'hffff));
        send_item(make_cmd(OP_INSERT, 1, 0, 0, "L", 16'h0000));
        send_item(make_cmd(OP_INSERT, 50, 12, 30, "X", 16'haaaa));
        send_item(make_cmd(OP_INSERT, 50, 12, 30, "M", 16'h5555));
        send_item(make_cmd(OP_INSERT, 50, 12, 29, "J", 16'h0101));
        send_item(make_cmd(OP_INSERT, 50, 12, 31, "V", 16'h0202));
        send_item(make_cmd(OP_INSERT, 1, 0, 0, "S", 16'h0303));
        // every weekday at one entry: tie goes to the earliest
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 8'h00, 16'h0000));
        send_item(make_cmd(OP_INSERT, 99, 1, 1, "D", 16'h0404));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 8'h00, 16'h0000));
        repeat (4) send_item(make_cmd(OP_POP, 0, 0, 0, 8'h00, 16'h0000));
        hold_until_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct  = 57;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct <= 57;
                end
                default:
                begin
                    idle_pct  = 12;
                    stall_pct <= 12;
                end
            endcase
            repeat (20) send_item(random_noise());
            // long enough to hit a full queue from any starting level
            repeat (70) send_item(random_insert());
            repeat (35) send_item(random_drain());
            hold_until_drained();
        end

        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("[sorted_priority_queue_with_day_tally] OK");
        else
            $display("[sorted_priority_queue_with_day_tally] ERROR");
        $finish;
    end

endmodule
